// ----- design/drap_pkg.sv -----
// Package for the DNS response answer parser.
// Holds the parse phase type and the fixed byte counts, offsets and pointer mark of the message format.
// No dependencies.
package drap_pkg;

  typedef enum logic [6:0] {
    PhHeader  = 7'b0000001,
    PhQname   = 7'b0000010,
    PhQfixed  = 7'b0000100,
    PhAname   = 7'b0001000,
    PhAfixed  = 7'b0010000,
    PhRdata   = 7'b0100000,
    PhDone    = 7'b1000000
  } phase_e;

  localparam logic [15:0] HeaderBytes        = 16'd12;
  localparam logic [15:0] QuestionFixedBytes = 16'd4;
  localparam logic [15:0] AnswerFixedBytes   = 16'd10;
  localparam logic [15:0] TypeClassTtlBytes  = 16'd8;
  localparam logic [15:0] AddressBytes       = 16'd4;
  localparam logic [15:0] CountHiByte        = 16'd6;
  localparam logic [15:0] CountLoByte        = 16'd7;
  localparam logic [7:0]  PointerMark        = 8'd192;

endpackage

// ----- design/drap_if.sv -----
// Channel interfaces of the DNS response answer parser.
// Byte input channel and answer record output channel, valid/ready.
// No dependencies.
interface drap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface drap_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] record_type;
  logic [15:0] record_class;
  logic [31:0] time_to_live;
  logic [15:0] data_length;
  logic [31:0] address;
  logic [15:0] answer_index;
  logic        status;
  logic        last_answer;

  modport source (
    output valid, output record_type, output record_class, output time_to_live,
    output data_length, output address, output answer_index, output status,
    output last_answer, input ready
  );
  modport sink (
    input valid, input record_type, input record_class, input time_to_live,
    input data_length, input address, input answer_index, input status,
    input last_answer, output ready
  );
endinterface

// ----- design/dns_response_answer_parser_core.sv -----
// DNS response answer parser: walks a response one byte per transaction.
// A result appears in the output register in the cycle after the byte that causes it.
// One byte is accepted every cycle; input stalls only while a result waits unread.
// Reset is asynchronous and active low; it clears the parse state and the output valid.
// Depends on drap_pkg and the interfaces in drap_if.sv.
module dns_response_answer_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  drap_in_if.sink           req_i,
  drap_out_if.source        rsp_o
);

  drap_pkg::phase_e phase_q, phase_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [5:0]  label_q, label_d;
  logic [15:0] total_q, total_d;
  logic [15:0] done_q, done_d;
  logic [63:0] shift_q, shift_d;
  logic [15:0] rdata_q, rdata_d;
  logic [31:0] addr_q, addr_d;

  logic        out_valid_q;
  logic [15:0] type_q, class_q, len_q, index_q;
  logic [31:0] ttl_q, out_addr_q;
  logic        status_q, last_q;

  logic        in_fire;
  logic [7:0]  b;
  logic        eom;
  logic [15:0] cnt_inc, rdata_dec, done_inc;
  logic        name_end;
  logic [15:0] name_cnt_d;
  logic [5:0]  name_label_d;
  logic        emit, trunc, load;
  logic [15:0] rec_len;
  logic [31:0] lane;

  function automatic logic [31:0] lane_sel(input logic [15:0] cnt, input logic [31:0] l);
    lane_sel = (cnt < drap_pkg::AddressBytes) ? l : 32'd0;
  endfunction

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;
  assign b           = req_i.data_byte;
  assign eom         = req_i.end_of_message;
  assign cnt_inc     = byte_cnt_q + 16'd1;
  assign rdata_dec   = rdata_q - 16'd1;
  assign done_inc    = done_q + 16'd1;

  // Name walk: a pending pointer byte, a label body byte, a zero terminator,
  // a pointer mark or a new label length.
  always_comb begin
    name_end     = 1'b0;
    name_cnt_d   = byte_cnt_q;
    name_label_d = label_q;
    if (byte_cnt_q != 16'd0) begin
      name_cnt_d = 16'd0;
      name_end   = 1'b1;
    end else if (label_q != 6'd0) begin
      name_label_d = label_q - 6'd1;
    end else if (b == 8'd0) begin
      name_end = 1'b1;
    end else if (b >= drap_pkg::PointerMark) begin
      name_cnt_d = 16'd1;
    end else begin
      name_label_d = b[5:0];
    end
  end

  always_comb begin
    case (byte_cnt_q[1:0])
      2'd0:    lane = {b, 24'd0};
      2'd1:    lane = {8'd0, b, 16'd0};
      2'd2:    lane = {16'd0, b, 8'd0};
      default: lane = {24'd0, b};
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    label_d    = label_q;
    total_d    = total_q;
    done_d     = done_q;
    shift_d    = shift_q;
    rdata_d    = rdata_q;
    addr_d     = addr_q;
    emit       = 1'b0;
    rec_len    = 16'd0;
    trunc      = 1'b0;
    if (in_fire) begin
      unique case (phase_q)
        drap_pkg::PhHeader: begin
          if (byte_cnt_q == drap_pkg::CountHiByte || byte_cnt_q == drap_pkg::CountLoByte) begin
            total_d = {total_q[7:0], b};
          end
          byte_cnt_d = cnt_inc;
          if (cnt_inc >= drap_pkg::HeaderBytes) begin
            byte_cnt_d = 16'd0;
            label_d    = 6'd0;
            phase_d    = drap_pkg::PhQname;
          end
        end
        drap_pkg::PhQname: begin
          byte_cnt_d = name_cnt_d;
          label_d    = name_label_d;
          if (name_end) begin
            phase_d = drap_pkg::PhQfixed;
          end
        end
        drap_pkg::PhQfixed: begin
          byte_cnt_d = cnt_inc;
          if (cnt_inc >= drap_pkg::QuestionFixedBytes) begin
            byte_cnt_d = 16'd0;
            label_d    = 6'd0;
            phase_d    = (done_q >= total_q) ? drap_pkg::PhDone : drap_pkg::PhAname;
          end
        end
        drap_pkg::PhAname: begin
          byte_cnt_d = name_cnt_d;
          label_d    = name_label_d;
          if (name_end) begin
            shift_d = 64'd0;
            rdata_d = 16'd0;
            addr_d  = 32'd0;
            phase_d = drap_pkg::PhAfixed;
          end
        end
        drap_pkg::PhAfixed: begin
          if (byte_cnt_q < drap_pkg::TypeClassTtlBytes) begin
            shift_d = {shift_q[55:0], b};
          end else begin
            rdata_d = {rdata_q[7:0], b};
          end
          byte_cnt_d = cnt_inc;
          if (cnt_inc >= drap_pkg::AnswerFixedBytes) begin
            byte_cnt_d = 16'd0;
            if (rdata_d == 16'd0) begin
              emit = 1'b1;
            end else begin
              phase_d = drap_pkg::PhRdata;
            end
          end
        end
        drap_pkg::PhRdata: begin
          if (byte_cnt_q < drap_pkg::AddressBytes) begin
            addr_d = addr_q | lane;
          end
          byte_cnt_d = cnt_inc;
          rdata_d    = rdata_dec;
          if (rdata_dec == 16'd0) begin
            emit    = 1'b1;
            rec_len = cnt_inc;
          end
        end
        drap_pkg::PhDone: begin
        end
        default: begin
        end
      endcase

      if (emit) begin
        done_d     = done_inc;
        byte_cnt_d = 16'd0;
        label_d    = 6'd0;
        phase_d    = (done_inc >= total_q) ? drap_pkg::PhDone : drap_pkg::PhAname;
      end

      if (eom) begin
        trunc      = (phase_d != drap_pkg::PhDone);
        phase_d    = drap_pkg::PhHeader;
        byte_cnt_d = 16'd0;
        label_d    = 6'd0;
        total_d    = 16'd0;
        done_d     = 16'd0;
        shift_d    = 64'd0;
        rdata_d    = 16'd0;
        addr_d     = 32'd0;
      end
    end
  end

  assign load = in_fire && (emit || trunc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= drap_pkg::PhHeader;
      byte_cnt_q  <= 16'd0;
      label_q     <= 6'd0;
      total_q     <= 16'd0;
      done_q      <= 16'd0;
      shift_q     <= 64'd0;
      rdata_q     <= 16'd0;
      addr_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      label_q    <= label_d;
      total_q    <= total_d;
      done_q     <= done_d;
      shift_q    <= shift_d;
      rdata_q    <= rdata_d;
      addr_q     <= addr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The record fields come from the values this byte completes, before any
  // end-of-message clearing.
  always_ff @(posedge clk_i) begin
    if (load) begin
      index_q <= done_q;
      status_q <= trunc;
      if (emit) begin
        type_q     <= shift_q[63:48];
        class_q    <= shift_q[47:32];
        ttl_q      <= shift_q[31:0];
        len_q      <= rec_len;
        out_addr_q <= (phase_q == drap_pkg::PhRdata) ? (addr_q | lane_sel(byte_cnt_q, lane))
                                                      : 32'd0;
        last_q     <= trunc || (done_inc == total_q);
      end else begin
        type_q     <= 16'd0;
        class_q    <= 16'd0;
        ttl_q      <= 32'd0;
        len_q      <= 16'd0;
        out_addr_q <= 32'd0;
        last_q     <= 1'b1;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.record_type  = type_q;
  assign rsp_o.record_class = class_q;
  assign rsp_o.time_to_live = ttl_q;
  assign rsp_o.data_length  = len_q;
  assign rsp_o.address      = out_addr_q;
  assign rsp_o.answer_index = index_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.last_answer  = last_q;

endmodule

// ----- design/drap_checker.sv -----
// Port-level checks for the DNS response answer parser.
// Watches the byte and record channels of dns_response_answer_parser_core.
// Bound to dns_response_answer_parser_core by the bind statement at the end of this file.
module drap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_index_i,
  input logic [31:0] out_address_i,
  input logic        out_status_i,
  input logic        out_last_i
);

  // A truncated message always closes the message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> out_last_i)
    else $error("truncation result without last_answer");

  // No byte is taken while a result waits unread.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while output stalled");

  // A new result needs an accepted byte in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without an accepted byte");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i)
      && $stable(out_address_i) && $stable(out_status_i))
    else $error("stalled result changed");

endmodule

bind dns_response_answer_parser_core drap_checker u_drap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_index_i   (rsp_o.answer_index),
  .out_address_i (rsp_o.address),
  .out_status_i  (rsp_o.status),
  .out_last_i    (rsp_o.last_answer)
);

// ----- verif/dns_response_answer_parser_core_tb.sv -----
// Self-checking testbench for the DNS response answer parser core.
// Streams whole and cut-short response messages, predicts every answer record and checks it.
// Depends on drap_pkg, the channel interfaces in drap_if.sv and the parser core.
`timescale 1ns / 100ps

module dns_response_answer_parser_core_tb;

  localparam int ClkPeriod     = 12;
  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 20;
  localparam int RandomBytes   = 450;
  localparam int MaxReports    = 10;

  typedef struct packed {
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] time_to_live;
    logic [15:0] data_length;
    logic [31:0] address;
    logic [15:0] answer_index;
    logic        status;
    logic        last_answer;
  } answer_rec_t;

  logic clk_i;
  logic rst_ni;

  drap_in_if  byte_ch ();
  drap_out_if rec_ch ();

  dns_response_answer_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (byte_ch),
    .rsp_o  (rec_ch)
  );

  answer_rec_t pending_records[$];
  logic [7:0]  msg_bytes[$];

  drap_pkg::phase_e walk_phase;
  logic [15:0] walk_count;
  logic [5:0]  walk_label;
  logic [15:0] walk_total;
  logic [15:0] walk_done;
  logic [63:0] walk_fixed;
  logic [15:0] walk_rdata_left;
  logic [31:0] walk_addr;

  int mismatches = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int records_seen = 0;
  int cut_short_seen = 0;
  bit no_gaps = 1'b0;
  int hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic void clear_walk();
    walk_phase      = drap_pkg::PhHeader;
    walk_count      = '0;
    walk_label      = '0;
    walk_total      = '0;
    walk_done       = '0;
    walk_fixed      = '0;
    walk_rdata_left = '0;
    walk_addr       = '0;
  endfunction

  function automatic bit name_byte_ends(input logic [7:0] b);
    if (walk_count != 0) begin
      walk_count = '0;
      return 1'b1;
    end
    if (walk_label != 0) begin
      walk_label = walk_label - 6'd1;
      return 1'b0;
    end
    if (b == 8'd0) return 1'b1;
    if (b >= drap_pkg::PointerMark) begin
      walk_count = 16'd1;
      return 1'b0;
    end
    walk_label = b[5:0];
    return 1'b0;
  endfunction

  function automatic void start_answers();
    walk_count = '0;
    walk_label = '0;
    walk_phase = (walk_done >= walk_total) ? drap_pkg::PhDone : drap_pkg::PhAname;
  endfunction

  function automatic answer_rec_t finish_answer(input logic [15:0] length);
    answer_rec_t rec;
    rec.record_type  = walk_fixed[63:48];
    rec.record_class = walk_fixed[47:32];
    rec.time_to_live = walk_fixed[31:0];
    rec.data_length  = length;
    rec.address      = walk_addr;
    rec.answer_index = walk_done;
    rec.status       = 1'b0;
    rec.last_answer  = ((walk_done + 16'd1) == walk_total);
    walk_done = walk_done + 16'd1;
    start_answers();
    return rec;
  endfunction

  function automatic void track_answer_byte(input logic [7:0] b, input logic eom);
    answer_rec_t rec;
    bit          produced;
    rec = '0;
    produced = 1'b0;
    case (walk_phase)
      drap_pkg::PhHeader: begin
        if (walk_count == drap_pkg::CountHiByte || walk_count == drap_pkg::CountLoByte) begin
          walk_total = {walk_total[7:0], b};
        end
        walk_count = walk_count + 16'd1;
        if (walk_count >= drap_pkg::HeaderBytes) begin
          walk_count = '0;
          walk_label = '0;
          walk_phase = drap_pkg::PhQname;
        end
      end
      drap_pkg::PhQname: begin
        if (name_byte_ends(b)) begin
          walk_count = '0;
          walk_phase = drap_pkg::PhQfixed;
        end
      end
      drap_pkg::PhQfixed: begin
        walk_count = walk_count + 16'd1;
        if (walk_count >= drap_pkg::QuestionFixedBytes) start_answers();
      end
      drap_pkg::PhAname: begin
        if (name_byte_ends(b)) begin
          walk_count      = '0;
          walk_fixed      = '0;
          walk_rdata_left = '0;
          walk_addr       = '0;
          walk_phase      = drap_pkg::PhAfixed;
        end
      end
      drap_pkg::PhAfixed: begin
        if (walk_count < drap_pkg::TypeClassTtlBytes) walk_fixed = {walk_fixed[55:0], b};
        else walk_rdata_left = {walk_rdata_left[7:0], b};
        walk_count = walk_count + 16'd1;
        if (walk_count >= drap_pkg::AnswerFixedBytes) begin
          walk_count = '0;
          if (walk_rdata_left == 0) begin
            rec = finish_answer(16'd0);
            produced = 1'b1;
          end else begin
            walk_phase = drap_pkg::PhRdata;
          end
        end
      end
      drap_pkg::PhRdata: begin
        if (walk_count < drap_pkg::AddressBytes) begin
          walk_addr = walk_addr | ({b, 24'h000000} >> (8 * walk_count));
        end
        walk_count = walk_count + 16'd1;
        walk_rdata_left = walk_rdata_left - 16'd1;
        if (walk_rdata_left == 0) begin
          rec = finish_answer(walk_count);
          produced = 1'b1;
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (walk_phase != drap_pkg::PhDone) begin
        if (!produced) begin
          rec = '0;
          rec.answer_index = walk_done;
        end
        rec.status = 1'b1;
        rec.last_answer = 1'b1;
        produced = 1'b1;
      end
      clear_walk();
    end
    if (produced) pending_records.push_back(rec);
  endfunction

  function automatic void check_record(input answer_rec_t got);
    answer_rec_t want;
    bit          differs;
    if (pending_records.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: unexpected result, index %0d status %b last %b",
                 $time, got.answer_index, got.status, got.last_answer);
      end
      return;
    end
    want = pending_records.pop_front();
    records_seen++;
    if (want.status) cut_short_seen++;
    differs = (got.record_type !== want.record_type) ||
              (got.record_class !== want.record_class) ||
              (got.time_to_live !== want.time_to_live) ||
              (got.data_length !== want.data_length) ||
              (got.address !== want.address) ||
              (got.answer_index !== want.answer_index) ||
              (got.status !== want.status) ||
              (got.last_answer !== want.last_answer);
    if (differs) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: expected type %h class %h ttl %h len %h addr %h idx %0d st %b last %b",
                 $time, want.record_type, want.record_class, want.time_to_live,
                 want.data_length, want.address, want.answer_index, want.status,
                 want.last_answer);
        $display("%0t: actual   type %h class %h ttl %h len %h addr %h idx %0d st %b last %b",
                 $time, got.record_type, got.record_class, got.time_to_live,
                 got.data_length, got.address, got.answer_index, got.status,
                 got.last_answer);
      end
    end
  endfunction

  always @(posedge clk_i) begin : transaction_monitor
    answer_rec_t got;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (rec_ch.valid && rec_ch.ready) begin
        got = {rec_ch.record_type, rec_ch.record_class, rec_ch.time_to_live,
               rec_ch.data_length, rec_ch.address, rec_ch.answer_index,
               rec_ch.status, rec_ch.last_answer};
        check_record(got);
        moved = 1'b1;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        track_answer_byte(byte_ch.data_byte, byte_ch.end_of_message);
        bytes_sent++;
        if (byte_ch.end_of_message) messages_sent++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : record_sink
    int stall;
    rec_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request != 0) begin
        rec_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rec_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rec_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rec_ch.valid && hold_request == 0);
    end
  end

  initial begin : watchdog
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("No transaction for %0d cycles, giving up.", WatchdogLimit);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.end_of_message <= eom;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_message(input int cut);
    for (int i = 0; i < cut; i++) send_byte(msg_bytes[i], i == cut - 1);
    msg_bytes.delete();
  endtask

  function automatic void put_byte(input logic [7:0] b);
    msg_bytes.push_back(b);
  endfunction

  function automatic void put_word(input logic [31:0] w, input int n);
    for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_rdata(input int n);
    repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_header(input logic [15:0] count);
    for (int i = 0; i < 12; i++) begin
      if (i == 6) msg_bytes.push_back(count[15:8]);
      else if (i == 7) msg_bytes.push_back(count[7:0]);
      else msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void put_label(input logic [7:0] len_byte);
    msg_bytes.push_back(len_byte);
    put_rdata(int'(len_byte[5:0]));
  endfunction

  function automatic void put_random_name();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 7) == 0) begin
        put_label(8'(64 * $urandom_range(1, 2) + $urandom_range(0, 6)));
      end else begin
        put_label(8'($urandom_range(1, 6)));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      put_byte(8'd0);
    end else begin
      put_byte(8'($urandom_range(192, 255)));
      put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void put_question();
    put_random_name();
    put_word($urandom, 4);
  endfunction

  function automatic void put_answer_fixed(input logic [15:0] rtype, input logic [15:0] rclass,
                                           input logic [31:0] ttl, input logic [15:0] rdlen);
    put_word({16'd0, rtype}, 2);
    put_word({16'd0, rclass}, 2);
    put_word(ttl, 4);
    put_word({16'd0, rdlen}, 2);
  endfunction

  function automatic void put_random_answer();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    put_random_name();
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'(len));
    put_rdata(len);
  endfunction

  task automatic test_empty_answer_section();
    put_header(16'd0);
    put_label(8'd3);
    put_byte(8'd0);
    put_word($urandom, 4);
    put_word($urandom, 3);
    send_message(msg_bytes.size());
    put_header(16'd0);
    put_byte(8'd0);
    put_word(32'h0001_0001, 4);
    send_message(msg_bytes.size());
  endtask

  task automatic test_field_extremes();
    put_header(16'd4);
    put_question();
    put_byte(8'd0);
    put_answer_fixed(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd4);
    put_word(32'hFFFF_FFFF, 4);
    put_byte(8'hC0);
    put_byte(8'h0C);
    put_answer_fixed(16'h0000, 16'h0000, 32'h0000_0000, 16'd0);
    put_random_name();
    put_answer_fixed(16'd1, 16'd1, $urandom, 16'd2);
    put_rdata(2);
    put_random_name();
    put_answer_fixed(16'd28, 16'd1, $urandom, 16'd6);
    put_rdata(6);
    send_message(msg_bytes.size());
  endtask

  task automatic test_name_forms();
    put_header(16'd3);
    put_label(8'h3F);
    put_label(8'h45);
    put_label(8'hBF);
    put_byte(8'd0);
    put_word($urandom, 4);
    put_byte(8'hC0);
    put_byte(8'h00);
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'd1);
    put_rdata(1);
    put_label(8'd2);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'd1);
    put_rdata(1);
    put_label(8'h40);
    put_byte(8'd0);
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'd1);
    put_rdata(1);
    send_message(msg_bytes.size());
  endtask

  task automatic test_cut_short_messages();
    put_byte(8'($urandom_range(0, 255)));
    send_message(1);
    put_header(16'd1);
    send_message(8);
    put_header(16'hFFFF);
    put_question();
    put_byte(8'd0);
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'd4);
    put_rdata(4);
    put_label(8'd5);
    send_message(msg_bytes.size());
    put_header(16'd2);
    put_question();
    put_random_name();
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'd3);
    put_rdata(3);
    send_message(msg_bytes.size());
    put_header(16'd2);
    put_question();
    put_random_name();
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'd0);
    send_message(msg_bytes.size());
    put_header(16'd1);
    put_question();
    put_random_name();
    put_answer_fixed(16'($urandom), 16'($urandom), $urandom, 16'hFFFF);
    put_rdata(5);
    send_message(msg_bytes.size());
  endtask

  task automatic test_back_pressure();
    no_gaps = 1'b1;
    hold_request = HoldOffCycles;
    put_header(16'd8);
    put_byte(8'd0);
    put_word($urandom, 4);
    repeat (8) begin
      put_byte(8'hC0);
      put_byte(8'h0C);
      put_answer_fixed(16'd1, 16'd1, $urandom, 16'd0);
    end
    send_message(msg_bytes.size());
    no_gaps = 1'b0;
  endtask

  task automatic test_random_messages();
    int first;
    int kind;
    int count;
    first = bytes_sent;
    while (bytes_sent - first < RandomBytes) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        put_rdata($urandom_range(1, 30));
        send_message(msg_bytes.size());
      end else begin
        count = $urandom_range(0, 4);
        put_header(16'(count));
        put_question();
        repeat (count) put_random_answer();
        if (kind < 5) begin
          send_message($urandom_range(1, msg_bytes.size()));
        end else begin
          if (kind < 8) put_rdata($urandom_range(1, 5));
          send_message(msg_bytes.size());
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.end_of_message <= 1'b0;
    clear_walk();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_answer_section();
    test_field_extremes();
    test_name_forms();
    test_cut_short_messages();
    test_back_pressure();
    test_random_messages();

    byte_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Streamed %0d bytes in %0d messages and checked %0d answer results.",
             bytes_sent, messages_sent, records_seen);
    $display("%0d results flagged a message cut short; %0d mismatches seen.",
             cut_short_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- dns_response_answer_parser_core.f -----
design/drap_pkg.sv
design/drap_if.sv
design/dns_response_answer_parser_core.sv
design/drap_checker.sv
verif/dns_response_answer_parser_core_tb.sv
